>>> src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
  localparam int CNT_WIDTH   = $clog2(WIDE_WIDTH) + 1;
  localparam int SHF_WIDTH   = $clog2(WIDE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [WIDE_WIDTH-1:0]  wide_t;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // largest positive value and magnitude of the most negative value
  localparam wide_t LIM_POS = wide_t'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam wide_t LIM_NEG = wide_t'(64'd1 << (VALUE_WIDTH - 1));

endpackage

>>> src/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply, divide and equality compare of two fractions,
// each operand and the result reduced by the gcd.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_op and the four operand ports and raise start while busy is low;
//   that edge is the input transfer. busy stays high until the result is out.
//   The result appears on the out_ ports for exactly one cycle with out_valid
//   high, and the receiver must take it then: there is no back pressure.
// Throughput and resources:
//   One item at a time. An item runs on a shared binary gcd unit (one
//   subtract or shift per cycle) and a shared restoring divider (64-bit
//   quotient) that together run up to four gcds and eight divisions per item.
//   A 32x32 multiplier with a registered product serves the products.
//   A zero operand denominator is reported in the cycle after the transfer.
// Reset:
//   rst_n low clears the sequencer and the units; the block comes up idle
//   with out_valid low. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rational_arith_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_op,
  input  logic signed [rau_pkg::VALUE_WIDTH-1:0] in_a_num,
  input  logic signed [rau_pkg::VALUE_WIDTH-1:0] in_a_den,
  input  logic signed [rau_pkg::VALUE_WIDTH-1:0] in_b_num,
  input  logic signed [rau_pkg::VALUE_WIDTH-1:0] in_b_den,
  output logic                         out_valid,
  output logic signed [rau_pkg::VALUE_WIDTH-1:0] out_res_num,
  output logic [rau_pkg::VALUE_WIDTH-2:0]        out_res_den,
  output logic                         out_is_equal,
  output logic [1:0]                   out_status
);
  import rau_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_A1   = 5'd1;
  localparam logic [4:0] S_A2   = 5'd2;
  localparam logic [4:0] S_A3   = 5'd3;
  localparam logic [4:0] S_B0   = 5'd4;
  localparam logic [4:0] S_B1   = 5'd5;
  localparam logic [4:0] S_B2   = 5'd6;
  localparam logic [4:0] S_B3   = 5'd7;
  localparam logic [4:0] S_OP   = 5'd8;
  localparam logic [4:0] S_M1   = 5'd9;
  localparam logic [4:0] S_M2   = 5'd10;
  localparam logic [4:0] S_S1   = 5'd11;
  localparam logic [4:0] S_S2   = 5'd12;
  localparam logic [4:0] S_S3   = 5'd13;
  localparam logic [4:0] S_S4   = 5'd14;
  localparam logic [4:0] S_S5   = 5'd15;
  localparam logic [4:0] S_S6   = 5'd16;
  localparam logic [4:0] S_RG   = 5'd17;
  localparam logic [4:0] S_R1   = 5'd18;
  localparam logic [4:0] S_R2   = 5'd19;
  localparam logic [4:0] S_R3   = 5'd20;
  localparam logic [4:0] S_CHK  = 5'd21;

  logic [4:0]  state_r, state_nxt;
  logic [2:0]  op_r;
  val_t        am_r, ad_r, bm_r, bd_r, t1_r;
  logic        aneg_r, bneg_r, rneg_r;
  wide_t       rm_r, rd_r, ta_r;

  // output registers
  logic        ovalid_r;
  val_t        onum_r;
  logic [VALUE_WIDTH-2:0] oden_r;
  logic        oeq_r;
  logic [1:0]  ost_r;

  // shared units
  wide_t       prod_r;
  val_t        mul_a, mul_b;
  logic        g_go, g_busy_r;
  wide_t       g_x_in, g_y_in, gx_r, gy_r, g_r;
  logic [SHF_WIDTH-1:0] gk_r;
  logic        d_go, d_busy_r;
  wide_t       d_n_in, d_d_in, dn_r, dd_r, drem_r;
  logic [CNT_WIDTH-1:0] dcnt_r;
  logic [WIDE_WIDTH:0]  d_trial;

  logic        stall;
  val_t        in_am, in_ad, in_bm, in_bd;
  logic        sb;
  wide_t       sum_mag;
  logic        sum_neg;
  logic        ovf;

  assign in_am = in_a_num[VALUE_WIDTH-1] ? (~in_a_num + 1'b1) : in_a_num;
  assign in_ad = in_a_den[VALUE_WIDTH-1] ? (~in_a_den + 1'b1) : in_a_den;
  assign in_bm = in_b_num[VALUE_WIDTH-1] ? (~in_b_num + 1'b1) : in_b_num;
  assign in_bd = in_b_den[VALUE_WIDTH-1] ? (~in_b_den + 1'b1) : in_b_den;

  assign stall = g_busy_r | d_busy_r;
  assign busy  = (state_r != S_IDLE);

  // sign of the second term of a sum; a zero term counts as positive
  assign sb = (bm_r == '0) ? 1'b0 : ((op_r == OP_SUB) ? ~bneg_r : bneg_r);

  always_comb begin
    if (aneg_r == sb) begin
      sum_mag = ta_r + prod_r;
      sum_neg = aneg_r;
    end else if (ta_r >= prod_r) begin
      sum_mag = ta_r - prod_r;
      sum_neg = aneg_r;
    end else begin
      sum_mag = prod_r - ta_r;
      sum_neg = sb;
    end
  end

  assign ovf = (rd_r > LIM_POS) || (rneg_r ? (rm_r > LIM_NEG) : (rm_r > LIM_POS));

  // unit launches per sequencer step
  always_comb begin
    g_go   = 1'b0;
    g_x_in = rm_r;
    g_y_in = rd_r;
    d_go   = 1'b0;
    d_n_in = rm_r;
    d_d_in = g_r;
    mul_a  = am_r;
    mul_b  = bm_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        g_x_in = wide_t'(in_am);
        g_y_in = wide_t'(in_ad);
        if (start) begin
          if (in_ad == '0 || in_bd == '0) begin
            state_nxt = S_IDLE;
          end else begin
            g_go      = 1'b1;
            state_nxt = S_A1;
          end
        end
      end
      S_A1: begin
        d_go = 1'b1; d_n_in = wide_t'(am_r); d_d_in = g_r; state_nxt = S_A2;
      end
      S_A2: begin
        d_go = 1'b1; d_n_in = wide_t'(ad_r); d_d_in = g_r; state_nxt = S_A3;
      end
      S_A3: state_nxt = S_B0;
      S_B0: begin
        g_go = 1'b1; g_x_in = wide_t'(bm_r); g_y_in = wide_t'(bd_r); state_nxt = S_B1;
      end
      S_B1: begin
        d_go = 1'b1; d_n_in = wide_t'(bm_r); d_d_in = g_r; state_nxt = S_B2;
      end
      S_B2: begin
        d_go = 1'b1; d_n_in = wide_t'(bd_r); d_d_in = g_r; state_nxt = S_B3;
      end
      S_B3: state_nxt = S_OP;
      S_OP: begin
        case (op_r)
          OP_ADD, OP_SUB: begin
            g_go = 1'b1; g_x_in = wide_t'(ad_r); g_y_in = wide_t'(bd_r);
            state_nxt = S_S1;
          end
          OP_MUL: begin
            mul_a = am_r; mul_b = bm_r; state_nxt = S_M1;
          end
          OP_DIV: begin
            mul_a = am_r; mul_b = bd_r;
            state_nxt = (bm_r == '0) ? S_IDLE : S_M1;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_M1: begin
        mul_a = ad_r; mul_b = (op_r == OP_MUL) ? bd_r : bm_r; state_nxt = S_M2;
      end
      S_M2: state_nxt = S_RG;
      S_S1: begin
        d_go = 1'b1; d_n_in = wide_t'(ad_r); d_d_in = g_r; state_nxt = S_S2;
      end
      S_S2: begin
        d_go = 1'b1; d_n_in = wide_t'(bd_r); d_d_in = g_r; state_nxt = S_S3;
      end
      S_S3: begin
        mul_a = t1_r; mul_b = bd_r; state_nxt = S_S4;
      end
      S_S4: begin
        mul_a = am_r; mul_b = val_t'(dn_r); state_nxt = S_S5;
      end
      S_S5: begin
        mul_a = bm_r; mul_b = t1_r; state_nxt = S_S6;
      end
      S_S6: state_nxt = S_RG;
      S_RG: begin
        g_go = 1'b1; g_x_in = rm_r; g_y_in = rd_r; state_nxt = S_R1;
      end
      S_R1: begin
        d_go = 1'b1; d_n_in = rm_r; d_d_in = g_r; state_nxt = S_R2;
      end
      S_R2: begin
        d_go = 1'b1; d_n_in = rd_r; d_d_in = g_r; state_nxt = S_R3;
      end
      S_R3: state_nxt = S_CHK;
      S_CHK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (stall && state_r != S_IDLE) begin
      g_go      = 1'b0;
      d_go      = 1'b0;
      state_nxt = state_r;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= 1'b0;
      if (state_r == S_IDLE && start) begin
        if (in_ad == '0 || in_bd == '0) begin
          ovalid_r <= 1'b1;
          onum_r   <= '0; oden_r <= '0; oeq_r <= 1'b0; ost_r <= ST_ZERO_DEN;
        end
      end else if (state_r == S_OP && !stall) begin
        if (op_r == OP_CMP) begin
          ovalid_r <= 1'b1;
          onum_r   <= '0; oden_r <= '0; ost_r <= ST_OK;
          oeq_r    <= (aneg_r == bneg_r) && (am_r == bm_r) && (ad_r == bd_r);
        end else if (op_r > OP_CMP) begin
          ovalid_r <= 1'b1;
          onum_r   <= '0; oden_r <= '0; oeq_r <= 1'b0; ost_r <= ST_OK;
        end else if (op_r == OP_DIV && bm_r == '0) begin
          ovalid_r <= 1'b1;
          onum_r   <= '0; oden_r <= '0; oeq_r <= 1'b0; ost_r <= ST_ZERO_DEN;
        end
      end else if (state_r == S_CHK) begin
        ovalid_r <= 1'b1;
        oeq_r    <= 1'b0;
        if (ovf) begin
          onum_r <= '0; oden_r <= '0; ost_r <= ST_OVERFLOW;
        end else begin
          onum_r <= rneg_r ? (~val_t'(rm_r) + 1'b1) : val_t'(rm_r);
          oden_r <= rd_r[VALUE_WIDTH-2:0];
          ost_r  <= ST_OK;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= WIDE_WIDTH'(mul_a) * WIDE_WIDTH'(mul_b);
    if (!stall) begin
      case (state_r)
        S_IDLE: begin
          op_r   <= in_op;
          am_r   <= in_am; ad_r <= in_ad; bm_r <= in_bm; bd_r <= in_bd;
          aneg_r <= in_a_num[VALUE_WIDTH-1] ^ in_a_den[VALUE_WIDTH-1];
          bneg_r <= in_b_num[VALUE_WIDTH-1] ^ in_b_den[VALUE_WIDTH-1];
        end
        S_A2:  am_r <= val_t'(dn_r);
        S_A3: begin
          ad_r   <= val_t'(dn_r);
          aneg_r <= aneg_r & (am_r != '0);
        end
        S_B2:  bm_r <= val_t'(dn_r);
        S_B3: begin
          bd_r   <= val_t'(dn_r);
          bneg_r <= bneg_r & (bm_r != '0);
        end
        S_OP:  rneg_r <= aneg_r ^ bneg_r;
        S_M1:  rm_r <= prod_r;
        S_M2:  rd_r <= prod_r;
        S_S2:  t1_r <= val_t'(dn_r);
        S_S4:  rd_r <= prod_r;
        S_S5:  ta_r <= prod_r;
        S_S6: begin
          rm_r   <= sum_mag;
          rneg_r <= sum_neg;
        end
        S_R2:  rm_r <= dn_r;
        S_R3:  rd_r <= dn_r;
        S_CHK: rneg_r <= rneg_r & (rm_r != '0);
        default: ;
      endcase
    end
  end

  // binary gcd: one shift or subtract per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_busy_r <= 1'b0;
    end else if (g_go) begin
      gx_r     <= g_x_in;
      gy_r     <= g_y_in;
      gk_r     <= '0;
      g_busy_r <= 1'b1;
    end else if (g_busy_r) begin
      if (gx_r == '0) begin
        g_r      <= gy_r << gk_r;
        g_busy_r <= 1'b0;
      end else if (gy_r == '0) begin
        g_r      <= gx_r << gk_r;
        g_busy_r <= 1'b0;
      end else if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gk_r <= gk_r + 1'b1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gy_r <= gy_r - gx_r;
      end
    end
  end

  // restoring divider: quotient shifts into dn_r, one bit per cycle
  assign d_trial = {drem_r, dn_r[WIDE_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_busy_r <= 1'b0;
    end else if (d_go) begin
      drem_r   <= '0;
      dn_r     <= d_n_in;
      dd_r     <= d_d_in;
      dcnt_r   <= CNT_WIDTH'(WIDE_WIDTH);
      d_busy_r <= 1'b1;
    end else if (d_busy_r) begin
      if (d_trial >= {1'b0, dd_r}) begin
        drem_r <= wide_t'(d_trial - {1'b0, dd_r});
        dn_r   <= {dn_r[WIDE_WIDTH-2:0], 1'b1};
      end else begin
        drem_r <= d_trial[WIDE_WIDTH-1:0];
        dn_r   <= {dn_r[WIDE_WIDTH-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == CNT_WIDTH'(1)) d_busy_r <= 1'b0;
    end
  end

  assign out_valid    = ovalid_r;
  assign out_res_num  = onum_r;
  assign out_res_den  = oden_r;
  assign out_is_equal = oeq_r;
  assign out_status   = ost_r;

endmodule
